@@ design/sdtr_pkg.sv @@
// Shared types and constants for the stepper DDS trapezoid ramp generator.
// Holds item mode codes, register indexes and datapath widths; no dependencies.
package sdtr_pkg;

  localparam int PHASE_WIDTH = 32;   // phase accumulator width, 16..48
  localparam int POS_WIDTH   = 32;   // position and target width, 16..32

  localparam int DATA_WIDTH  = 32;   // registers, speed and port fields
  localparam int CFG_IDX_W   = 2;

  // phase + speed, with room for the carry out of the accumulator
  localparam int SUM_W = ((PHASE_WIDTH > DATA_WIDTH) ? PHASE_WIDTH : DATA_WIDTH) + 1;
  // magnitude of goal - position
  localparam int REM_W = POS_WIDTH + 1;
  // width for the distance-versus-limit compare
  localparam int CMP_W = DATA_WIDTH + 1;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_STOP = 2'd2,
    MODE_ZERO = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_STEPS = 2'd0,
    REG_MIN_SPEED  = 2'd1,
    REG_MAX_SPEED  = 2'd2,
    REG_ACCEL      = 2'd3
  } reg_idx_t;

endpackage

@@ design/stepper_dds_trapezoid_ramp.sv @@
// Stepper pulse generator top level: DDS phase accumulator with trapezoid ramp.
// Depends on sdtr_pkg for widths, mode codes and register indexes.

// Items are ticks or commands (move to target, stop, zero position). An item is
// latched into an input register, then adds and compares against the motion
// state produce the result register and the new state. out_valid rises as the
// item is loaded into the result register, which a stalled result holds off.
// One item is taken every cycle while the result side keeps up; the input
// register and the result register decouple the two channels, so one item can
// wait behind a stalled result. Configuration writes are always accepted
// (cfg_ready is always high) and should be issued while no item is in flight.
// Each item yields exactly one result: step and direction pin levels,
// position, current speed and an at-target flag.
module stepper_dds_trapezoid_ramp (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic signed [31:0]                  in_target,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_step_level,
  output logic                                out_dir_level,
  output logic signed [31:0]                  out_position,
  output logic [31:0]                         out_speed_now,
  output logic                                out_at_target,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sdtr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdtr_pkg::DATA_WIDTH-1:0]     cfg_data
);

  localparam int PW  = sdtr_pkg::PHASE_WIDTH;
  localparam int QW  = sdtr_pkg::POS_WIDTH;
  localparam int DW  = sdtr_pkg::DATA_WIDTH;
  localparam int SW  = sdtr_pkg::SUM_W;
  localparam int RW  = sdtr_pkg::REM_W;
  localparam int CW  = sdtr_pkg::CMP_W;

  // configuration
  logic [DW-1:0] ramp_steps_r, min_speed_r, max_speed_r, accel_r;

  // input register
  logic                 s1_valid_r;
  sdtr_pkg::mode_t      s1_mode_r;
  logic signed [31:0]   s1_target_r;

  // motion state
  logic signed [QW-1:0] pos_r, pos_nxt;
  logic signed [QW-1:0] goal_r, goal_nxt;
  logic [DW-1:0]        count_r, count_nxt;
  logic [DW-1:0]        speed_r, speed_nxt;
  logic [PW-1:0]        phase_r, phase_nxt;
  logic                 step_r, step_nxt;
  logic                 dir_r, dir_nxt;

  // result register
  logic                 out_valid_r;
  logic                 o_step_r, o_dir_r, o_at_r;
  logic signed [31:0]   o_pos_r;
  logic [DW-1:0]        o_speed_r;

  logic advance;

  // tick datapath
  logic [SW-1:0]        phase_sum;
  logic                 carry;
  logic signed [RW-1:0] diff;
  logic [RW-1:0]        rem_old, rem_new;
  logic [DW-1:0]        count_tick;
  logic [DW-1:0]        limit;
  logic                 brake;
  logic                 above_floor;
  logic signed [QW-1:0] target_q;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;

  assign target_q  = s1_target_r[QW-1:0];

  always_comb begin
    phase_sum   = SW'(phase_r) + SW'(speed_r);
    carry       = |phase_sum[SW-1:PW];
    diff        = RW'(goal_r) - RW'(pos_r);
    rem_old     = diff[RW-1] ? RW'(-diff) : RW'(diff);
    // a step always moves toward the goal, so the distance drops by one
    rem_new     = carry ? (rem_old - RW'(1)) : rem_old;
    count_tick  = carry ? (count_r + DW'(1)) : count_r;
    limit       = (count_tick < ramp_steps_r) ? count_tick : ramp_steps_r;
    brake       = CW'(rem_new) <= CW'(limit);
    above_floor = CW'(speed_r) > (CW'(min_speed_r) + CW'(accel_r));

    pos_nxt   = pos_r;
    goal_nxt  = goal_r;
    count_nxt = count_r;
    speed_nxt = speed_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    dir_nxt   = dir_r;

    case (s1_mode_r)
      sdtr_pkg::MODE_TICK: begin
        step_nxt = 1'b0;
        if (pos_r == goal_r) begin
          speed_nxt = '0;
        end else begin
          phase_nxt = phase_sum[PW-1:0];
          count_nxt = count_tick;
          if (carry) begin
            step_nxt = 1'b1;
            pos_nxt  = (goal_r > pos_r) ? (pos_r + QW'(1)) : (pos_r - QW'(1));
          end
          if (brake) begin
            speed_nxt = above_floor ? (speed_r - accel_r) : min_speed_r;
          end else if (speed_r < max_speed_r) begin
            speed_nxt = speed_r + accel_r;
          end
        end
      end
      sdtr_pkg::MODE_MOVE: begin
        goal_nxt = target_q;
        // a move to the current position leaves direction and count alone
        if (target_q > pos_r) begin
          dir_nxt   = 1'b1;
          count_nxt = '0;
        end else if (target_q < pos_r) begin
          dir_nxt   = 1'b0;
          count_nxt = '0;
        end
      end
      sdtr_pkg::MODE_STOP: begin
        speed_nxt = '0;
        goal_nxt  = pos_r;
      end
      sdtr_pkg::MODE_ZERO: begin
        pos_nxt = '0;
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_steps_r <= '0;
      min_speed_r  <= '0;
      max_speed_r  <= '0;
      accel_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (sdtr_pkg::reg_idx_t'(cfg_index))
        sdtr_pkg::REG_RAMP_STEPS: ramp_steps_r <= cfg_data;
        sdtr_pkg::REG_MIN_SPEED:  min_speed_r  <= cfg_data;
        sdtr_pkg::REG_MAX_SPEED:  max_speed_r  <= cfg_data;
        sdtr_pkg::REG_ACCEL:      accel_r      <= cfg_data;
        default:                  accel_r      <= accel_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r   <= sdtr_pkg::mode_t'(in_mode);
      s1_target_r <= in_target;
    end
  end

  // motion state, updated as each item passes to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      goal_r  <= '0;
      count_r <= '0;
      speed_r <= '0;
      phase_r <= '0;
      step_r  <= 1'b0;
      dir_r   <= 1'b0;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      goal_r  <= goal_nxt;
      count_r <= count_nxt;
      speed_r <= speed_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      dir_r   <= dir_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_step_r  <= step_nxt;
      o_dir_r   <= dir_nxt;
      o_pos_r   <= 32'(pos_nxt);
      o_speed_r <= speed_nxt;
      o_at_r    <= (pos_nxt == goal_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_level = o_step_r;
  assign out_dir_level  = o_dir_r;
  assign out_position   = o_pos_r;
  assign out_speed_now  = o_speed_r;
  assign out_at_target  = o_at_r;

`ifndef SYNTHESIS
  // a held item and a stalled result leave no room for another item
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("item accepted with both stages full");

  // a tick taken at the target brings the motor to rest
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_mode_r == sdtr_pkg::MODE_TICK && pos_r == goal_r)
      |=> (out_speed_now == '0 && out_at_target && !out_step_level))
    else $error("tick at target did not stop the motor");

  // commands never change the step pin
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_mode_r != sdtr_pkg::MODE_TICK) |=> (step_r == $past(step_r)))
    else $error("command changed the step level");
`endif

endmodule

@@ test/tb_stepper_dds_trapezoid_ramp.sv @@
`timescale 1ns / 1ps
// Testbench for stepper_dds_trapezoid_ramp: ticks and commands go in under random stalls,
// and a scoreboard predicts the pin levels, position and speed for each item and checks them.
// Depends on sdtr_pkg and the block's RTL only.

module tb_stepper_dds_trapezoid_ramp;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 37;

  typedef struct packed {
    logic        step_lvl;
    logic        dir_lvl;
    logic [31:0] position;
    logic [31:0] speed;
    logic        at_target;
  } pin_state_t;

  // Motion state and ramp registers, plus the levels still owed by the block
  class ramp_tracker;
    logic [31:0]        ramp_steps = '0;
    logic [31:0]        min_inc    = '0;
    logic [31:0]        max_inc    = '0;
    logic [31:0]        accel      = '0;
    logic signed [31:0] pos        = '0;
    logic signed [31:0] goal       = '0;
    logic [31:0]        moved      = '0;
    logic [31:0]        speed      = '0;
    logic [31:0]        phase      = '0;
    logic               step_lvl   = 1'b0;
    logic               dir_lvl    = 1'b0;
    pin_state_t         levels_due[$];
    int unsigned        errors  = 0;
    int unsigned        checked = 0;
    int unsigned        steps   = 0;
    int unsigned        moves   = 0;

    function void set_reg(sdtr_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        sdtr_pkg::REG_RAMP_STEPS: ramp_steps = val;
        sdtr_pkg::REG_MIN_SPEED:  min_inc = val;
        sdtr_pkg::REG_MAX_SPEED:  max_inc = val;
        sdtr_pkg::REG_ACCEL:      accel = val;
        default:                  accel = accel;
      endcase
    endfunction

    function void advance_tick();
      logic [32:0]        phase_sum;
      logic signed [32:0] gap;
      logic [32:0]        gap_abs;
      logic [31:0]        limit;
      step_lvl = 1'b0;
      if (pos == goal) begin
        speed = '0;
      end else begin
        phase_sum = {1'b0, phase} + {1'b0, speed};
        phase = phase_sum[31:0];
        // carry out of the accumulator: one step toward the goal
        if (phase_sum[32]) begin
          step_lvl = 1'b1;
          pos = (goal > pos) ? pos + 1 : pos - 1;
          moved = moved + 1;
          steps++;
        end
        gap = {goal[31], goal} - {pos[31], pos};
        gap_abs = gap[32] ? -gap : gap;
        limit = (moved < ramp_steps) ? moved : ramp_steps;
        if (gap_abs <= {1'b0, limit}) begin
          // brake compare is done without wrap
          if ({1'b0, speed} > {1'b0, min_inc} + {1'b0, accel}) speed = speed - accel;
          else speed = min_inc;
        end else if (speed < max_inc) begin
          speed = speed + accel;
        end
      end
    endfunction

    function void note_item(sdtr_pkg::mode_t mode, logic [31:0] tgt);
      pin_state_t due;
      case (mode)
        sdtr_pkg::MODE_TICK: advance_tick();
        sdtr_pkg::MODE_MOVE: begin
          goal = tgt;
          moves++;
          // a move to the current position keeps direction and step count
          if (goal > pos) begin
            dir_lvl = 1'b1;
            moved = '0;
          end else if (goal < pos) begin
            dir_lvl = 1'b0;
            moved = '0;
          end
        end
        sdtr_pkg::MODE_STOP: begin
          speed = '0;
          goal = pos;
        end
        sdtr_pkg::MODE_ZERO: pos = '0;
        default: pos = pos;
      endcase
      due.step_lvl  = step_lvl;
      due.dir_lvl   = dir_lvl;
      due.position  = pos;
      due.speed     = speed;
      due.at_target = (pos == goal);
      levels_due.push_back(due);
    endfunction

    function int waiting();
      return levels_due.size();
    endfunction

    function void check_result(pin_state_t got);
      pin_state_t want;
      if (levels_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing outstanding: pos %0d speed %h",
                   $signed(got.position), got.speed);
      end else begin
        want = levels_due.pop_front();
        checked++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch (exp/got): step %b/%b dir %b/%b pos %0d/%0d speed %h/%h at %b/%b",
                     want.step_lvl, got.step_lvl, want.dir_lvl, got.dir_lvl,
                     $signed(want.position), $signed(got.position),
                     want.speed, got.speed, want.at_target, got.at_target);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [31:0] in_target;
  logic        out_valid;
  logic        out_ready;
  logic        out_step_level;
  logic        out_dir_level;
  logic [31:0] out_position;
  logic [31:0] out_speed_now;
  logic        out_at_target;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [sdtr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sdtr_pkg::DATA_WIDTH-1:0] cfg_data;

  ramp_tracker tracker = new();
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycles = 0;
  logic        tx_idle_en = 1'b1;
  logic        rx_idle_en = 1'b1;
  logic        hold_req = 1'b0;

  stepper_dds_trapezoid_ramp uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_target      (in_target),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_step_level (out_step_level),
    .out_dir_level  (out_dir_level),
    .out_position   (out_position),
    .out_speed_now  (out_speed_now),
    .out_at_target  (out_at_target),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random back-pressure, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !rx_idle_en || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result({out_step_level, out_dir_level, out_position,
                            out_speed_now, out_at_target});
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_stepper_dds_trapezoid_ramp: done, errors");
    $finish;
  end

  task automatic send_item(sdtr_pkg::mode_t mode, logic [31:0] tgt);
    if (tx_idle_en) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_target <= tgt;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(mode, tgt);
    items_sent++;
  endtask

  // Hold input off until every outstanding item has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
  endtask

  task automatic write_reg(sdtr_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
  endtask

  task automatic load_ramp(logic [31:0] ramp, logic [31:0] lo, logic [31:0] hi,
                           logic [31:0] acc);
    write_reg(sdtr_pkg::REG_RAMP_STEPS, ramp);
    write_reg(sdtr_pkg::REG_MIN_SPEED, lo);
    write_reg(sdtr_pkg::REG_MAX_SPEED, hi);
    write_reg(sdtr_pkg::REG_ACCEL, acc);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly short moves followed by ticks, with stray commands and far moves mixed in
  task automatic run_burst(int unsigned n);
    int unsigned start_count;
    int unsigned roll;
    int unsigned hop;
    logic [31:0] aim;
    start_count = items_sent;
    while (items_sent - start_count < n) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        hop = $urandom_range(1, 40);
        aim = $urandom_range(1) ? tracker.pos + hop : tracker.pos - hop;
        send_item(sdtr_pkg::MODE_MOVE, aim);
        repeat ($urandom_range(4, 80)) begin
          if (items_sent - start_count >= n) break;
          if ($urandom_range(99) < 3)
            send_item($urandom_range(1) ? sdtr_pkg::MODE_STOP : sdtr_pkg::MODE_ZERO,
                      $urandom);
          else
            send_item(sdtr_pkg::MODE_TICK, $urandom);
        end
      end else if (roll < 85) begin
        send_item(sdtr_pkg::mode_t'($urandom_range(3)), $urandom);
      end else begin
        send_item(sdtr_pkg::MODE_MOVE, $urandom);
        repeat ($urandom_range(1, 12)) begin
          if (items_sent - start_count >= n) break;
          send_item(sdtr_pkg::MODE_TICK, $urandom);
        end
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_mode   = sdtr_pkg::MODE_TICK;
    in_target = '0;
    cfg_valid = 1'b0;
    cfg_index = sdtr_pkg::REG_RAMP_STEPS;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // out of reset: registers all zero, tick at target and move in place
    send_item(sdtr_pkg::MODE_TICK, 32'h0);
    send_item(sdtr_pkg::MODE_MOVE, 32'h0);
    drain();
    load_ramp(32'd2, 32'h8000_0000, 32'hFFFF_FFFF, 32'h4000_0000);
    send_item(sdtr_pkg::MODE_MOVE, 32'd3);
    repeat (6) send_item(sdtr_pkg::MODE_TICK, 32'h0);
    send_item(sdtr_pkg::MODE_STOP, 32'h0);
    send_item(sdtr_pkg::MODE_MOVE, 32'h8000_0000);
    repeat (2) send_item(sdtr_pkg::MODE_TICK, 32'h0);
    send_item(sdtr_pkg::MODE_STOP, 32'hFFFF_FFFF);
    send_item(sdtr_pkg::MODE_MOVE, 32'h7FFF_FFFF);
    repeat (2) send_item(sdtr_pkg::MODE_TICK, 32'h0);
    send_item(sdtr_pkg::MODE_ZERO, 32'hFFFF_FFFF);
    send_item(sdtr_pkg::MODE_TICK, 32'h0);
    send_item(sdtr_pkg::MODE_STOP, 32'h0);
    send_item(sdtr_pkg::MODE_MOVE, tracker.pos);
    send_item(sdtr_pkg::MODE_TICK, 32'hFFFF_FFFF);
    send_item(sdtr_pkg::MODE_ZERO, 32'h5A5A_A5A5);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      tx_idle_en = (ph != 3);
      rx_idle_en = (ph != 3);
      case (ph)
        0: load_ramp('0, '0, '0, '0);
        1: load_ramp(32'd5, 32'h1000_0000, 32'hC000_0000, 32'h0800_0000);
        2: load_ramp('1, '1, '1, '1);
        4: load_ramp($urandom, $urandom, $urandom, $urandom);
        5: load_ramp(32'd3, 32'h2000_0000, 32'hF000_0000, 32'h1000_0000);
        default: load_ramp($urandom_range(0, 15), $urandom >> $urandom_range(0, 4),
                           $urandom, $urandom >> $urandom_range(0, 8));
      endcase
      // fill the block while the receiver holds off
      if (ph == 5) hold_req = 1'b1;
      run_burst((ph == 0) ? 20 : 100);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("ran %0d items over %0d ramp settings: %0d moves, %0d steps emitted",
             items_sent, settings_used, tracker.moves, tracker.steps);
    $display("checked %0d results, %0d mismatches", tracker.checked, tracker.errors);
    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("tb_stepper_dds_trapezoid_ramp: done, clean");
    end else begin
      $display("tb_stepper_dds_trapezoid_ramp: done, errors");
    end
    $finish;
  end

endmodule
